### hdl/framed_packet_receiver_top_assert.svh
// Assertion macros for the framed packet receiver.
// Used by framed_packet_receiver_top.sv; needs nothing else.
`ifndef FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset.
`define FPR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define FPR_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Antecedent implies consequent at the next edge.
`define FPR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define FPR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define FPR_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define FPR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

### hdl/fpr_pkg.sv
// Types and codes for the framed packet receiver.
// No dependencies; imported by framed_packet_receiver_top.
`default_nettype none

package fpr_pkg;

   typedef logic [7:0] byte_type;

   // Receiver state, also reported as the item status.
   typedef enum logic [2:0] {
      ST_START  = 3'd0,
      ST_LENGTH = 3'd1,
      ST_DATA   = 3'd2,
      ST_CHECK  = 3'd3,
      ST_END    = 3'd4,
      ST_DONE   = 3'd5,
      ST_ERROR  = 3'd6
   } state_type;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_START_CODE = 2'd0;
   localparam csr_index_type CSR_END_CODE   = 2'd1;

   localparam byte_type START_CODE_RESET = 8'h02;
   localparam byte_type END_CODE_RESET   = 8'h03;

endpackage

`default_nettype wire

### hdl/framed_packet_receiver_top.sv
// Framed packet receiver: start / length / payload / XOR check / end parser.
// Each accepted byte yields one result item, registered in the output register.
// Throughput: 1 byte per cycle while the result register is not stalled; the parser
// state update is combinational and feeds the result register directly.
// Reset (synchronous, active high): hunt for start code, counters and check
// cleared, start/end codes back to 0x02/0x03, output register empty.
`default_nettype none

`include "framed_packet_receiver_top_assert.svh"

module framed_packet_receiver_top
   import fpr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 255   // 1..255
)(
   input  wire logic          clock,
   input  wire logic          reset,

   // received byte channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_rx_byte,

   // result channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_data_valid,
   output logic [7:0]         rsp_data_byte,
   output logic [7:0]         rsp_data_index,
   output logic [7:0]         rsp_frame_length,
   output logic               rsp_frame_done,
   output logic               rsp_frame_error,

   // configuration writes
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_write_data
);

   localparam byte_type MAX_PAYLOAD_BYTE = 8'(MAX_PAYLOAD);

   // ---------------------------------------------------------------
   // Handshake: the output register parts the two sides. A new byte is
   // taken unless the result register holds an item that is stalled.
   // ---------------------------------------------------------------
   logic req_accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   byte_type start_code_ff;
   byte_type end_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_CODE: start_code_ff <= csr_write_data;
            CSR_END_CODE:   end_code_ff   <= csr_write_data;
            default: ;      // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   byte_type  count_ff, count_in;     // payload bytes taken so far
   byte_type  check_ff, check_in;     // running XOR, seeded by start byte
   byte_type  length_ff, length_in;   // length byte of current frame

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_START;
         count_ff  <= '0;
         check_ff  <= '0;
         length_ff <= '0;
      end else if (req_accept) begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         check_ff  <= check_in;
         length_ff <= length_in;
      end
   end

   // per-item result, before the output register
   logic     data_valid_in;
   byte_type data_byte_in;
   byte_type data_index_in;
   logic     frame_done_in;
   logic     frame_error_in;

   always_comb begin
      byte_type count_inc;
      count_inc      = count_ff + 8'd1;

      state_in       = state_ff;
      count_in       = count_ff;
      check_in       = check_ff;
      length_in      = length_ff;
      data_valid_in  = 1'b0;
      data_byte_in   = '0;
      data_index_in  = '0;
      frame_done_in  = 1'b0;
      frame_error_in = 1'b0;

      unique case (state_ff)
         ST_START: begin
            // anything but the start code is dropped while hunting
            if (req_rx_byte == start_code_ff) begin
               check_in = req_rx_byte;
               count_in = '0;
               state_in = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            length_in = req_rx_byte;
            check_in  = check_ff ^ req_rx_byte;
            count_in  = '0;
            if (req_rx_byte > MAX_PAYLOAD_BYTE) begin
               state_in       = ST_ERROR;
               frame_error_in = 1'b1;
            end else if (req_rx_byte == 8'd0) begin
               state_in = ST_CHECK;   // empty payload
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (count_ff < MAX_PAYLOAD_BYTE) begin
               data_valid_in = 1'b1;
               data_byte_in  = req_rx_byte;
               data_index_in = count_ff;
               check_in      = check_ff ^ req_rx_byte;
               count_in      = count_inc;
               if (count_inc >= length_ff) begin
                  state_in = ST_CHECK;
               end
            end else begin
               // overrun guard; the length bound keeps this from firing
               state_in       = ST_ERROR;
               frame_error_in = 1'b1;
            end
         end
         ST_CHECK: begin
            if (req_rx_byte == check_ff) begin
               state_in = ST_END;
            end else begin
               state_in       = ST_ERROR;
               frame_error_in = 1'b1;
            end
         end
         ST_END: begin
            if (req_rx_byte == end_code_ff) begin
               state_in      = ST_DONE;
               frame_done_in = 1'b1;
            end else begin
               state_in       = ST_ERROR;
               frame_error_in = 1'b1;
            end
         end
         default: ;   // done and error hold until reset
      endcase
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   state_type rsp_status_ff;
   logic      rsp_data_valid_ff;
   byte_type  rsp_data_byte_ff;
   byte_type  rsp_data_index_ff;
   byte_type  rsp_frame_length_ff;
   logic      rsp_frame_done_ff;
   logic      rsp_frame_error_ff;

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff       <= state_in;
         rsp_data_valid_ff   <= data_valid_in;
         rsp_data_byte_ff    <= data_byte_in;
         rsp_data_index_ff   <= data_index_in;
         rsp_frame_length_ff <= length_in;
         rsp_frame_done_ff   <= frame_done_in;
         rsp_frame_error_ff  <= frame_error_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_valid   = rsp_data_valid_ff;
   assign rsp_data_byte    = rsp_data_byte_ff;
   assign rsp_data_index   = rsp_data_index_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_frame_done   = rsp_frame_done_ff;
   assign rsp_frame_error  = rsp_frame_error_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `FPR_ASSERT_IMPLY(a_done_status, clock, reset, rsp_valid && rsp_frame_done,
      rsp_status == ST_DONE && !rsp_frame_error, "done pulse without done status")
   `FPR_ASSERT_IMPLY(a_error_status, clock, reset, rsp_valid && rsp_frame_error,
      rsp_status == ST_ERROR, "error pulse without error status")
   `FPR_ASSERT_IMPLY(a_payload_index, clock, reset, rsp_valid && rsp_data_valid,
      rsp_data_index < rsp_frame_length, "payload index outside frame length")
   `FPR_ASSERT_NEXT(a_done_sticky, clock, reset, state_ff == ST_DONE,
      state_ff == ST_DONE, "done state left without reset")
   `FPR_ASSERT_NEXT(a_error_sticky, clock, reset, state_ff == ST_ERROR,
      state_ff == ST_ERROR, "error state left without reset")

endmodule

`default_nettype wire

### verif/tb_framed_packet_receiver_top.sv
// Testbench for framed_packet_receiver_top: directed and random byte streams with a stall
// handshake on both sides, checked item by item against a frame parser kept in the bench.
// Depends on fpr_pkg and framed_packet_receiver_top only.
`timescale 1ns / 100ps

module tb_framed_packet_receiver_top
   import fpr_pkg::*;
();

   localparam int unsigned FRAME_MAX   = 255;
   localparam int          CYCLE_LIMIT = 100000;
   localparam int          GAP_PCT     = 8;

   // The index port is two bits wide. Indexes 2 and 3 have no register, so writes to them
   // must do nothing.
   localparam csr_index_type CSR_SPARE_2 = 2'd2;
   localparam csr_index_type CSR_SPARE_3 = 2'd3;

   // One result item as the parser reports it.
   typedef struct packed {
      state_type status;
      logic      data_valid;
      byte_type  data_byte;
      byte_type  data_index;
      byte_type  frame_length;
      logic      frame_done;
      logic      frame_error;
   } rx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid   = 1'b0;
   logic          req_stall;
   logic [7:0]    req_rx_byte = 8'h00;

   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [2:0]    rsp_status;
   logic          rsp_data_valid;
   logic [7:0]    rsp_data_byte;
   logic [7:0]    rsp_data_index;
   logic [7:0]    rsp_frame_length;
   logic          rsp_frame_done;
   logic          rsp_frame_error;

   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index        = CSR_START_CODE;
   logic [7:0]    csr_write_data   = 8'h00;

   // Bytes waiting to be sent, and the result items still to come from the block.
   byte_type      pending_rx_bytes[$];
   rx_result_type expected_status_items[$];

   int mismatch_count = 0;
   int cycle_count    = 0;

   // When this is low, neither side inserts gaps or stalls.
   bit gaps_on = 1'b1;

   // Parser state kept by the bench. It starts at the reset values.
   state_type model_state    = ST_START;
   byte_type  payload_count  = 8'h00;
   byte_type  check_acc      = 8'h00;
   byte_type  length_seen    = 8'h00;
   byte_type  start_code_cfg = START_CODE_RESET;
   byte_type  end_code_cfg   = END_CODE_RESET;

   framed_packet_receiver_top #(
      .MAX_PAYLOAD(FRAME_MAX)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_index  (rsp_data_index),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_frame_error (rsp_frame_error),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the bench parser by one received byte and return the item it expects.
   function automatic rx_result_type parse_byte(byte_type b);
      rx_result_type r;
      r = '0;
      case (model_state)
         ST_START: begin
            // While hunting, any byte other than the start code is dropped.
            if (b == start_code_cfg) begin
               check_acc     = b;
               payload_count = 8'h00;
               model_state   = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            length_seen   = b;
            check_acc     = check_acc ^ b;
            payload_count = 8'h00;
            if (int'(b) > FRAME_MAX) begin
               model_state   = ST_ERROR;
               r.frame_error = 1'b1;
            end else if (b == 8'h00) begin
               model_state = ST_CHECK;   // empty frame: no payload bytes
            end else begin
               model_state = ST_DATA;
            end
         end
         ST_DATA: begin
            if (int'(payload_count) < FRAME_MAX) begin
               r.data_valid  = 1'b1;
               r.data_byte   = b;
               r.data_index  = payload_count;
               check_acc     = check_acc ^ b;
               payload_count = payload_count + 8'd1;
               if (payload_count >= length_seen) model_state = ST_CHECK;
            end else begin
               model_state   = ST_ERROR;
               r.frame_error = 1'b1;
            end
         end
         ST_CHECK: begin
            if (b == check_acc) begin
               model_state = ST_END;
            end else begin
               model_state   = ST_ERROR;
               r.frame_error = 1'b1;
            end
         end
         ST_END: begin
            if (b == end_code_cfg) begin
               model_state  = ST_DONE;
               r.frame_done = 1'b1;
            end else begin
               model_state   = ST_ERROR;
               r.frame_error = 1'b1;
            end
         end
         default: ;   // done and error are sticky
      endcase
      r.status       = model_state;
      r.frame_length = length_seen;
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("%0t: result item mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Block idle: nothing left to send or in flight, every result item received.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_rx_bytes.size() != 0 || req_valid || expected_status_items.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Only called while the block is idle. The bench copy changes with the write.
   task automatic write_code(csr_index_type idx, byte_type val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      if (idx == CSR_START_CODE) start_code_cfg = val;
      else if (idx == CSR_END_CODE) end_code_cfg = val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random hunting noise. It never holds the current start code.
   task automatic add_noise(int n);
      byte_type b;
      for (int i = 0; i < n; i++) begin
         b = byte_type'($urandom_range(0, 255));
         if (b == start_code_cfg) b = b ^ 8'h01;
         pending_rx_bytes.push_back(b);
      end
   endtask

   // Driver. It holds a byte until it is accepted, then takes the next one from the queue.
   // The item is predicted at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) expected_status_items.push_back(parse_byte(req_rx_byte));
         if (!req_valid || !req_stall) begin
            if (pending_rx_bytes.size() != 0 &&
                !(gaps_on && $urandom_range(0, 99) < GAP_PCT)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_rx_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. It stalls at random and checks each accepted item against the oldest expectation.
   always @(posedge clock) begin
      rx_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_items.size() == 0) begin
               flag_mismatch("item with no expectation waiting");
            end else begin
               want = expected_status_items.pop_front();
               if (rsp_status != want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_data_valid != want.data_valid)
                  flag_mismatch($sformatf("data_valid %0b, want %0b",
                                          rsp_data_valid, want.data_valid));
               if (rsp_data_byte != want.data_byte)
                  flag_mismatch($sformatf("data_byte %02h, want %02h",
                                          rsp_data_byte, want.data_byte));
               if (rsp_data_index != want.data_index)
                  flag_mismatch($sformatf("data_index %0d, want %0d",
                                          rsp_data_index, want.data_index));
               if (rsp_frame_length != want.frame_length)
                  flag_mismatch($sformatf("frame_length %0d, want %0d",
                                          rsp_frame_length, want.frame_length));
               if (rsp_frame_done != want.frame_done)
                  flag_mismatch($sformatf("frame_done %0b, want %0b",
                                          rsp_frame_done, want.frame_done));
               if (rsp_frame_error != want.frame_error)
                  flag_mismatch($sformatf("frame_error %0b, want %0b",
                                          rsp_frame_error, want.frame_error));
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus. Reset happens once, and done and error are sticky, so the run can parse only
   // one frame. Most items are therefore hunting noise under several code settings. A single
   // random frame comes last, followed by a tail of bytes that the sticky state must ignore.
   initial begin
      int       len_sel;
      int       end_sel;
      int       frame_len_gen;
      byte_type gen_check;
      byte_type b;
      byte_type dir_bytes[];

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset codes (start 0x02): the byte extremes, the end code and near misses.
      dir_bytes = '{8'h00, 8'hFF, 8'h03, 8'h01, 8'h80, 8'h7F, 8'hFE};
      foreach (dir_bytes[i]) pending_rx_bytes.push_back(dir_bytes[i]);
      wait_for_drain();

      // Extreme codes. 0x02 no longer opens a frame.
      write_code(CSR_START_CODE, 8'hFF);
      write_code(CSR_END_CODE, 8'h00);
      @(negedge clock);
      dir_bytes = '{8'h00, 8'h02, 8'h03, 8'hFE, 8'h7F};
      foreach (dir_bytes[i]) pending_rx_bytes.push_back(dir_bytes[i]);
      wait_for_drain();

      write_code(CSR_START_CODE, 8'h00);
      write_code(CSR_END_CODE, 8'hFF);
      // Writes to the unused indexes must leave both codes as they are.
      write_code(CSR_SPARE_2, 8'h5A);
      write_code(CSR_SPARE_3, 8'hA5);
      @(negedge clock);
      dir_bytes = '{8'hFF, 8'h02, 8'h01, 8'h80};
      foreach (dir_bytes[i]) pending_rx_bytes.push_back(dir_bytes[i]);
      wait_for_drain();

      // Random code settings, each with a long burst of noise. Phase 2 has no gaps or stalls.
      for (int p = 0; p < 5; p++) begin
         write_code(CSR_START_CODE, byte_type'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) write_code(CSR_END_CODE, byte_type'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) == 0)
            write_code($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                       byte_type'($urandom_range(0, 255)));
         gaps_on = (p != 2);
         @(negedge clock);
         add_noise($urandom_range(300, 350));
         wait_for_drain();
      end
      gaps_on = 1'b1;

      // The one frame. The length is usually random, sometimes empty and sometimes full size.
      // It ends well most of the time, otherwise with a bad check byte or a bad end code.
      write_code(CSR_START_CODE, byte_type'($urandom_range(0, 255)));
      write_code(CSR_END_CODE, byte_type'($urandom_range(0, 255)));
      len_sel = $urandom_range(0, 9);
      end_sel = $urandom_range(0, 5);
      if (len_sel == 0) frame_len_gen = 0;
      else if (len_sel == 1) frame_len_gen = FRAME_MAX;
      else frame_len_gen = $urandom_range(1, FRAME_MAX - 1);
      @(negedge clock);
      add_noise($urandom_range(5, 20));
      pending_rx_bytes.push_back(start_code_cfg);
      pending_rx_bytes.push_back(byte_type'(frame_len_gen));
      gen_check = start_code_cfg ^ byte_type'(frame_len_gen);
      // The payload may hold copies of the start or end code. Both must pass through as data.
      for (int i = 0; i < frame_len_gen; i++) begin
         case ($urandom_range(0, 9))
            0:       b = start_code_cfg;
            1:       b = end_code_cfg;
            default: b = byte_type'($urandom_range(0, 255));
         endcase
         gen_check = gen_check ^ b;
         pending_rx_bytes.push_back(b);
      end

      // Hold the sender until the payload has drained. Then change the end code in the middle
      // of the frame; the end byte must be checked against the new value.
      wait_for_drain();
      write_code(CSR_END_CODE, byte_type'($urandom_range(0, 255)));
      @(negedge clock);
      if (end_sel == 0) gen_check = gen_check ^ byte_type'($urandom_range(1, 255));
      pending_rx_bytes.push_back(gen_check);
      if (end_sel == 1)
         pending_rx_bytes.push_back(end_code_cfg ^ byte_type'($urandom_range(1, 255)));
      else pending_rx_bytes.push_back(end_code_cfg);

      // Tail: the state is sticky now, so start codes and whole frames are ignored.
      for (int i = 0; i < 60; i++) begin
         if ($urandom_range(0, 3) == 0) pending_rx_bytes.push_back(start_code_cfg);
         else pending_rx_bytes.push_back(byte_type'($urandom_range(0, 255)));
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/fpr_pkg.sv
hdl/framed_packet_receiver_top.sv
verif/tb_framed_packet_receiver_top.sv
